FILE: rtl/dft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot frame transmitter package
// Shared widths, codes, configuration and result types, frame helpers.
// ----------------------------------------------------------------------------
package dft_pkg;

	localparam int VAL_W    = 11;
	localparam int CYC_W    = 12;
	localparam int RAW_W    = 16;
	localparam int FRAME_W  = 16;
	localparam int IDX_W    = $clog2(FRAME_W);
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 3;

	localparam int CMD_QUEUE_DEPTH = 8;
	localparam int QPTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

	localparam logic [VAL_W-1:0] RESET_VALUE = VAL_W'(48);

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_TELEM = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FRAME  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THR_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_TEL_ALWAYS = 3'd7;

	typedef struct packed {
		logic [VAL_W-1:0] throttle_min;
		logic [VAL_W-1:0] throttle_max;
		logic [VAL_W-1:0] command_min;
		logic [CYC_W-1:0] one_high_cycles;
		logic [CYC_W-1:0] one_low_cycles;
		logic [CYC_W-1:0] zero_high_cycles;
		logic [CYC_W-1:0] zero_low_cycles;
		logic             telemetry_always;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic [1:0]         status;
		logic [FRAME_W-1:0] frame;
	} res_t;

	// {value, telemetry, xor of the three payload nibbles}
	function automatic logic [FRAME_W-1:0] frame_build(input logic [VAL_W-1:0] value,
			input logic tel);
		logic [VAL_W:0] payload;
		logic [3:0]     csum;
		payload = {value, tel};
		csum    = payload[3:0] ^ payload[7:4] ^ payload[11:8];
		return {payload, csum};
	endfunction

	function automatic logic [CYC_W-1:0] at_least_one(input logic [CYC_W-1:0] v);
		return (v == '0) ? CYC_W'(1) : v;
	endfunction

endpackage

FILE: rtl/dft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/dft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot front end
// Classify requests, run the command queue RAM and build the frame word.
// ----------------------------------------------------------------------------
module dft_front import dft_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [RAW_W-1:0] raw_value,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	localparam int SUM_W = QCNT_W + 1;

	typedef enum logic [1:0] {SRC_KEEP, SRC_QUEUE, SRC_MBOX} src_t;

	logic              valid_s1;
	logic              kind_s1;
	logic [1:0]        status_s1;
	src_t              src_s1;
	logic [VAL_W-1:0]  mbox_s1;
	logic              tel_s1;

	logic [QCNT_W-1:0] cnt_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic              pending_q;
	logic [VAL_W-1:0]  mbox_q;
	logic              tel_once_q;
	logic [VAL_W-1:0]  cur_val_q;

	logic              in_acc;
	logic              is_thr;
	logic              is_bad;
	logic              q_full;
	logic [VAL_W-1:0]  thr_val;
	logic [SUM_W-1:0]  ptr_sum;
	logic [QPTR_W-1:0] wr_ptr;
	logic [QPTR_W-1:0] rd_ptr_nxt;
	logic              ram_we;
	logic              ram_re;
	logic [VAL_W-1:0]  ram_rdata;
	logic [VAL_W-1:0]  sel_value;
	logic              tel_now;

	always_comb begin
		in_stall = valid_s1 && !res_ready;
		in_acc   = in_valid && !in_stall;
		is_thr   = raw_value >= RAW_W'(cfg.throttle_min);
		is_bad   = raw_value < RAW_W'(cfg.command_min);
		q_full   = cnt_q == QCNT_W'(CMD_QUEUE_DEPTH);
		thr_val  = (raw_value > RAW_W'(cfg.throttle_max)) ? cfg.throttle_max
			: raw_value[VAL_W-1:0];
		ptr_sum  = SUM_W'(rd_ptr_q) + SUM_W'(cnt_q);
		wr_ptr   = (ptr_sum >= SUM_W'(CMD_QUEUE_DEPTH))
			? QPTR_W'(ptr_sum - SUM_W'(CMD_QUEUE_DEPTH)) : QPTR_W'(ptr_sum);
		rd_ptr_nxt = (rd_ptr_q == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		ram_we   = in_acc && req_type == REQ_WRITE && !is_thr && !is_bad && !q_full;
		ram_re   = in_acc && req_type == REQ_TICK && cnt_q != '0;
		tel_now  = cfg.telemetry_always || tel_once_q;
	end

	// a pop reads only an entry written in an earlier cycle, so the
	// registered read always sees the stored command
	dft_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_ptr),
		.wdata(raw_value[VAL_W-1:0]),
		.re   (ram_re),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			cnt_q      <= '0;
			rd_ptr_q   <= '0;
			pending_q  <= 1'b0;
			tel_once_q <= 1'b0;
			cur_val_q  <= RESET_VALUE;
		end else begin
			if (valid_s1 && res_ready && kind_s1 == KIND_FRAME) begin
				cur_val_q <= sel_value;
			end
			if (in_acc) begin
				valid_s1 <= req_type != REQ_SPARE;
				unique case (req_type)
					REQ_WRITE: begin
						if (is_thr) begin
							pending_q <= 1'b1;
						end else if (ram_we) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					REQ_TELEM: begin
						tel_once_q <= 1'b1;
					end
					REQ_TICK: begin
						if (cnt_q != '0) begin
							cnt_q    <= cnt_q - 1'b1;
							rd_ptr_q <= rd_ptr_nxt;
						end else begin
							pending_q <= 1'b0;
						end
						if (!cfg.telemetry_always) begin
							tel_once_q <= 1'b0;
						end
					end
					REQ_SPARE: begin
					end
					default: begin
					end
				endcase
			end else if (res_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1   <= (req_type == REQ_TICK) ? KIND_FRAME : KIND_STATUS;
			tel_s1    <= tel_now;
			mbox_s1   <= mbox_q;
			if (cnt_q != '0) begin
				src_s1 <= SRC_QUEUE;
			end else if (pending_q) begin
				src_s1 <= SRC_MBOX;
			end else begin
				src_s1 <= SRC_KEEP;
			end
			if (req_type == REQ_WRITE && !is_thr && is_bad) begin
				status_s1 <= ST_INVALID;
			end else if (req_type == REQ_WRITE && !is_thr && q_full) begin
				status_s1 <= ST_FULL;
			end else begin
				status_s1 <= ST_OK;
			end
		end
		if (in_acc && req_type == REQ_WRITE && is_thr) begin
			mbox_q <= thr_val;
		end
	end

	always_comb begin
		case (src_s1)
			SRC_QUEUE: sel_value = ram_rdata;
			SRC_MBOX:  sel_value = mbox_s1;
			default:   sel_value = cur_val_q;
		endcase
		res_valid  = valid_s1;
		res.kind   = kind_s1;
		res.status = status_s1;
		res.frame  = (kind_s1 == KIND_FRAME) ? frame_build(sel_value, tel_s1) : '0;
	end

endmodule

FILE: rtl/dft_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot result serializer
// Hold one result and shift a frame out MSB first with its pulse lengths.
// ----------------------------------------------------------------------------
module dft_serial import dft_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               res_valid,
	output logic               res_ready,
	input  res_t               res,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [1:0]         status,
	output logic               bit_value,
	output logic [CYC_W-1:0]   pulse_high,
	output logic [CYC_W-1:0]   pulse_low,
	output logic [FRAME_W-1:0] frame_word,
	output logic               last
);

	logic             busy_q;
	res_t             item_q;
	logic [IDX_W-1:0] idx_q;
	logic             xfer;
	logic             bit_now;

	always_comb begin
		xfer        = busy_q && !out_stall;
		bit_now     = item_q.frame[idx_q];
		out_valid   = busy_q;
		result_kind = item_q.kind;
		status      = item_q.status;
		frame_word  = item_q.frame;
		last        = (item_q.kind == KIND_STATUS) || idx_q == '0;
		res_ready   = !busy_q || (xfer && last);
		if (item_q.kind == KIND_FRAME) begin
			bit_value  = bit_now;
			pulse_high = at_least_one(bit_now ? cfg.one_high_cycles : cfg.zero_high_cycles);
			pulse_low  = at_least_one(bit_now ? cfg.one_low_cycles : cfg.zero_low_cycles);
		end else begin
			bit_value  = 1'b0;
			pulse_high = '0;
			pulse_low  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (res_ready) begin
			busy_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			item_q <= res;
			idx_q  <= IDX_W'(FRAME_W - 1);
		end else if (xfer) begin
			idx_q <= idx_q - 1'b1;
		end
	end

endmodule

FILE: rtl/dshot_frame_transmitter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot frame transmitter core
// Queues commands, holds the latest throttle and emits 16-bit DShot frames.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the front end's stage register and then the
//   serializer's result register before its result is offered at the output.
// Throughput: one request per cycle while in_stall is low; a write or telemetry
//   request yields one result, a frame tick yields one result per frame bit,
//   paced by the serializer's bit counter, and a spare request yields none.
// Reset: registers take their defaults, queue empty, current value 48. The
//   queue RAM is not cleared; entries are only read after being written.
module dshot_frame_transmitter_core import dft_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [RAW_W-1:0]     raw_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 result_kind,
	output logic [1:0]           status,
	output logic                 bit_value,
	output logic [CYC_W-1:0]     pulse_high,
	output logic [CYC_W-1:0]     pulse_low,
	output logic [FRAME_W-1:0]   frame_word,
	output logic                 last
);

	cfg_t cfg_q;
	logic res_valid;
	logic res_ready;
	res_t res;

	// Configuration registers: written only while the core is idle, a rule the user must keep
	// and the block does not enforce, so the front end and the serializer read them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.throttle_min     <= VAL_W'(48);
			cfg_q.throttle_max     <= VAL_W'(2047);
			cfg_q.command_min      <= VAL_W'(1);
			cfg_q.one_high_cycles  <= CYC_W'(60);
			cfg_q.one_low_cycles   <= CYC_W'(20);
			cfg_q.zero_high_cycles <= CYC_W'(30);
			cfg_q.zero_low_cycles  <= CYC_W'(50);
			cfg_q.telemetry_always <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THR_MIN:    cfg_q.throttle_min     <= cfg_data[VAL_W-1:0];
				CFG_THR_MAX:    cfg_q.throttle_max     <= cfg_data[VAL_W-1:0];
				CFG_CMD_MIN:    cfg_q.command_min      <= cfg_data[VAL_W-1:0];
				CFG_ONE_HIGH:   cfg_q.one_high_cycles  <= cfg_data;
				CFG_ONE_LOW:    cfg_q.one_low_cycles   <= cfg_data;
				CFG_ZERO_HIGH:  cfg_q.zero_high_cycles <= cfg_data;
				CFG_ZERO_LOW:   cfg_q.zero_low_cycles  <= cfg_data;
				CFG_TEL_ALWAYS: cfg_q.telemetry_always <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Front end: classify each transfer, push or pop the command queue RAM,
	// pick the frame value and build the frame word in stage one.
	dft_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.raw_value(raw_value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Serializer: hold the result register and advance one frame bit per
	// output transfer; it takes the next result as the last one leaves.
	dft_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_kind(result_kind),
		.status     (status),
		.bit_value  (bit_value),
		.pulse_high (pulse_high),
		.pulse_low  (pulse_low),
		.frame_word (frame_word),
		.last       (last)
	);

endmodule

FILE: rtl/dft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot frame transmitter checker
// Port-level properties of the result stream.
// ----------------------------------------------------------------------------
module dft_checker import dft_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               result_kind,
	input logic               bit_value,
	input logic [CYC_W-1:0]   pulse_high,
	input logic [CYC_W-1:0]   pulse_low,
	input logic [FRAME_W-1:0] frame_word,
	input logic               last
);

	// a frame keeps going after a bit that is not its last
	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && result_kind == KIND_FRAME && !last
		|=> out_valid && result_kind == KIND_FRAME && $stable(frame_word))
		else $error("frame cut short or changed");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_STATUS
		|-> last && !bit_value && pulse_high == '0 && pulse_low == '0
			&& frame_word == '0)
		else $error("malformed status reply");

	a_pulse_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_FRAME
		|-> pulse_high != '0 && pulse_low != '0)
		else $error("zero pulse length");

	a_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_FRAME
		|-> frame_word[3:0] == (frame_word[7:4] ^ frame_word[11:8] ^ frame_word[15:12]))
		else $error("bad frame checksum");

endmodule

bind dshot_frame_transmitter_core dft_checker u_dft_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.result_kind(result_kind),
	.bit_value  (bit_value),
	.pulse_high (pulse_high),
	.pulse_low  (pulse_low),
	.frame_word (frame_word),
	.last       (last)
);

FILE: tb/dshot_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot frame transmitter checker package
// Result type and a scoreboard that predicts status replies and frame bits.
// ----------------------------------------------------------------------------
package dshot_tb_pkg;
	import dft_pkg::*;

	typedef struct packed {
		logic               kind;
		logic [1:0]         status;
		logic               bit_value;
		logic [CYC_W-1:0]   pulse_high;
		logic [CYC_W-1:0]   pulse_low;
		logic [FRAME_W-1:0] frame;
		logic               last;
	} dshot_result_t;

	class frame_scoreboard;
		localparam int MAX_PRINTED = 40;

		cfg_t             cfg;
		logic [VAL_W-1:0] queued_cmds[$];
		logic             throttle_waiting;
		logic [VAL_W-1:0] throttle_mailbox;
		logic [VAL_W-1:0] sent_value;
		logic             tel_once;
		dshot_result_t    awaited[$];
		int unsigned      mismatches;

		function new();
			cfg.throttle_min     = VAL_W'(48);
			cfg.throttle_max     = VAL_W'(2047);
			cfg.command_min      = VAL_W'(1);
			cfg.one_high_cycles  = CYC_W'(60);
			cfg.one_low_cycles   = CYC_W'(20);
			cfg.zero_high_cycles = CYC_W'(30);
			cfg.zero_low_cycles  = CYC_W'(50);
			cfg.telemetry_always = 1'b0;
			throttle_waiting     = 1'b0;
			throttle_mailbox     = '0;
			sent_value           = RESET_VALUE;
			tel_once             = 1'b0;
			mismatches           = 0;
		endfunction

		function void write_config(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
			case (idx)
				CFG_THR_MIN:    cfg.throttle_min     = data[VAL_W-1:0];
				CFG_THR_MAX:    cfg.throttle_max     = data[VAL_W-1:0];
				CFG_CMD_MIN:    cfg.command_min      = data[VAL_W-1:0];
				CFG_ONE_HIGH:   cfg.one_high_cycles  = data;
				CFG_ONE_LOW:    cfg.one_low_cycles   = data;
				CFG_ZERO_HIGH:  cfg.zero_high_cycles = data;
				CFG_ZERO_LOW:   cfg.zero_low_cycles  = data;
				CFG_TEL_ALWAYS: cfg.telemetry_always = data[0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void expect_status(input logic [1:0] st);
			dshot_result_t r;
			r        = '0;
			r.kind   = KIND_STATUS;
			r.status = st;
			r.last   = 1'b1;
			awaited.push_back(r);
		endfunction

		// a zero pulse register still yields a one-cycle pulse
		function logic [CYC_W-1:0] min_one(input logic [CYC_W-1:0] v);
			return (v == '0) ? CYC_W'(1) : v;
		endfunction

		function void predict_tick();
			logic [VAL_W:0]     payload;
			logic [3:0]         csum;
			logic [FRAME_W-1:0] word;
			logic               tel;
			dshot_result_t      r;
			// commands win over a waiting throttle; otherwise repeat the last value
			if (queued_cmds.size() > 0) begin
				sent_value = queued_cmds.pop_front();
			end else if (throttle_waiting) begin
				sent_value       = throttle_mailbox;
				throttle_waiting = 1'b0;
			end
			tel = 1'b0;
			if (cfg.telemetry_always) begin
				tel = 1'b1;
			end else if (tel_once) begin
				tel      = 1'b1;
				tel_once = 1'b0;
			end
			payload = {sent_value, tel};
			csum    = '0;
			for (int n = 0; n < 3; n++)
				csum ^= payload[n*4 +: 4];
			word = {payload, csum};
			for (int b = FRAME_W - 1; b >= 0; b--) begin
				r.kind       = KIND_FRAME;
				r.status     = ST_OK;
				r.bit_value  = word[b];
				r.pulse_high = min_one(word[b] ? cfg.one_high_cycles : cfg.zero_high_cycles);
				r.pulse_low  = min_one(word[b] ? cfg.one_low_cycles : cfg.zero_low_cycles);
				r.frame      = word;
				r.last       = (b == 0);
				awaited.push_back(r);
			end
		endfunction

		function void predict_write(input logic [RAW_W-1:0] raw);
			logic [RAW_W-1:0] v;
			v = raw;
			if (v >= RAW_W'(cfg.throttle_min)) begin
				if (v > RAW_W'(cfg.throttle_max))
					v = RAW_W'(cfg.throttle_max);
				throttle_mailbox = v[VAL_W-1:0];
				throttle_waiting = 1'b1;
				expect_status(ST_OK);
			end else if (v < RAW_W'(cfg.command_min)) begin
				expect_status(ST_INVALID);
			end else if (queued_cmds.size() >= CMD_QUEUE_DEPTH) begin
				expect_status(ST_FULL);
			end else begin
				queued_cmds.push_back(v[VAL_W-1:0]);
				expect_status(ST_OK);
			end
		endfunction

		// note one accepted request and queue what it must produce
		function void note_request(input logic [1:0] req, input logic [RAW_W-1:0] raw);
			case (req)
				REQ_WRITE: predict_write(raw);
				REQ_TELEM: begin
					tel_once = 1'b1;
					expect_status(ST_OK);
				end
				REQ_TICK:  predict_tick();
				default: ;
			endcase
		endfunction

		task report(input string what, input int unsigned got, input int unsigned want);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got,
					want);
		endtask

		task check_result(input dshot_result_t got);
			dshot_result_t want;
			if (awaited.size() == 0) begin
				report("result with nothing outstanding", got.frame, 0);
			end else begin
				want = awaited.pop_front();
				if (got.kind !== want.kind)
					report("result_kind", got.kind, want.kind);
				if (got.status !== want.status)
					report("status", got.status, want.status);
				if (got.bit_value !== want.bit_value)
					report("bit_value", got.bit_value, want.bit_value);
				if (got.pulse_high !== want.pulse_high)
					report("pulse_high", got.pulse_high, want.pulse_high);
				if (got.pulse_low !== want.pulse_low)
					report("pulse_low", got.pulse_low, want.pulse_low);
				if (got.frame !== want.frame)
					report("frame_word", got.frame, want.frame);
				if (got.last !== want.last)
					report("last", got.last, want.last);
			end
		endtask
	endclass

endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DShot frame transmitter testbench
// Drives writes, telemetry requests and frame ticks through several register
// settings and back-pressure patterns; checks every result in order against
// a scoreboard that tracks the command queue, mailbox and telemetry flag.
// ----------------------------------------------------------------------------
module testbench;
	import dft_pkg::*;
	import dshot_tb_pkg::*;

	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 30;
	localparam int DRAIN_SLACK    = 12;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int QUIET_LIMIT    = 3000;
	localparam int VAL_TOP        = (1 << VAL_W) - 1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           req_type;
	logic [RAW_W-1:0]     raw_value;
	logic                 out_valid;
	logic                 out_stall;
	logic                 result_kind;
	logic [1:0]           status;
	logic                 bit_value;
	logic [CYC_W-1:0]     pulse_high;
	logic [CYC_W-1:0]     pulse_low;
	logic [FRAME_W-1:0]   frame_word;
	logic                 last;

	frame_scoreboard board;
	int unsigned     send_idle_pct;
	int unsigned     recv_stall_pct;
	bit              hold_off_req;

	dshot_frame_transmitter_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.raw_value   (raw_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.status      (status),
		.bit_value   (bit_value),
		.pulse_high  (pulse_high),
		.pulse_low   (pulse_low),
		.frame_word  (frame_word),
		.last        (last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Offer one request, starting and ending on a falling edge. The valid line
	// stays high after the transfer so back-to-back requests never drop it; the
	// caller lowers it once the burst is over.
	task automatic send_request(input logic [1:0] req, input logic [RAW_W-1:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= req;
		raw_value <= raw;
		// hold the payload until the block takes it
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		board.note_request(req, raw);
		@(negedge clk);
	endtask

	// Write one register; the enable stays high across consecutive writes.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		board.write_config(idx, data);
	endtask

	// Wait until every predicted result is back, then give requests that
	// produce nothing (the spare code) time to leave the pipeline.
	task automatic settle();
		while (board.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_SLACK) @(negedge clk);
	endtask

	// Upper bit of the 11-bit registers is junk the block must drop.
	function automatic logic [CFG_W-1:0] val_reg(input int unsigned v);
		return {1'($urandom_range(1)), VAL_W'(v)};
	endfunction

	task automatic program_phase(input int p);
		logic [CFG_W-1:0] thr_min, thr_max, cmd_min, one_hi, one_lo, zero_hi, zero_lo, tel;
		case (p)
			0: begin
				// power-on values, written explicitly
				thr_min = 48;   thr_max = 2047; cmd_min = 1;
				one_hi  = 60;   one_lo  = 20;   zero_hi = 30;   zero_lo = 50;   tel = 0;
			end
			1: begin
				// everything below the top is a command; longest pulses; telemetry on
				thr_min = val_reg(VAL_TOP); thr_max = val_reg(VAL_TOP); cmd_min = val_reg(0);
				one_hi  = 4095; one_lo  = 4095; zero_hi = 4095; zero_lo = 4095; tel = 1;
			end
			2: begin
				// every write is a throttle clamped to zero; zero pulse registers
				thr_min = 0;    thr_max = 0;    cmd_min = 0;
				one_hi  = 0;    one_lo  = 0;    zero_hi = 0;    zero_lo = 0;    tel = 0;
			end
			3: begin
				// clamp ceiling below the throttle floor; no command can pass
				thr_min = 1000; thr_max = 500;  cmd_min = val_reg(VAL_TOP);
				one_hi  = 1;    one_lo  = 4095; zero_hi = 0;    zero_lo = 1;
				tel     = {11'($urandom), 1'b0};
			end
			default: begin
				thr_min = val_reg($urandom_range(400, 8));
				thr_max = val_reg($urandom_range(VAL_TOP, 0));
				cmd_min = val_reg($urandom_range(12, 0));
				one_hi  = CFG_W'($urandom);
				one_lo  = CFG_W'($urandom);
				zero_hi = CFG_W'($urandom);
				zero_lo = CFG_W'($urandom);
				tel     = CFG_W'($urandom);
			end
		endcase
		write_register(CFG_THR_MIN, thr_min);
		write_register(CFG_THR_MAX, thr_max);
		write_register(CFG_CMD_MIN, cmd_min);
		write_register(CFG_ONE_HIGH, one_hi);
		write_register(CFG_ONE_LOW, one_lo);
		write_register(CFG_ZERO_HIGH, zero_hi);
		write_register(CFG_ZERO_LOW, zero_lo);
		write_register(CFG_TEL_ALWAYS, tel);
		cfg_we <= 1'b0;
	endtask

	// Mostly valid commands and throttles for the current setting, with some
	// rejected values and raw 16-bit noise mixed in.
	function automatic logic [RAW_W-1:0] pick_raw();
		int unsigned thr_lo, cmd_lo, sel;
		thr_lo = board.cfg.throttle_min;
		cmd_lo = board.cfg.command_min;
		sel    = $urandom_range(9);
		if (sel < 4 && cmd_lo < thr_lo)
			return RAW_W'($urandom_range(thr_lo - 1, cmd_lo));
		if (sel < 7)
			return RAW_W'($urandom_range(VAL_TOP, thr_lo));
		if (sel == 7 && cmd_lo > 0)
			return RAW_W'($urandom_range(cmd_lo - 1, 0));
		return RAW_W'($urandom);
	endfunction

	// Receiver: random stall each cycle, or one long hold-off on request while
	// the sender keeps pushing so the block backs up into its input.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Check each transfer on the result side at the rising edge.
	always @(posedge clk) begin
		dshot_result_t got;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got.kind       = result_kind;
			got.status     = status;
			got.bit_value  = bit_value;
			got.pulse_high = pulse_high;
			got.pulse_low  = pulse_low;
			got.frame      = frame_word;
			got.last       = last;
			board.check_result(got);
		end
	end

	// Abort if neither side completes a transfer for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned n;
		board          = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_req   = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		req_type       = REQ_WRITE;
		raw_value      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass under power-on settings.
		send_request(REQ_TICK, '0);              // reset value, no telemetry
		send_request(REQ_SPARE, '1);             // spare code: ignored
		send_request(REQ_WRITE, '0);             // below command floor
		send_request(REQ_WRITE, '1);             // huge throttle, clamped
		send_request(REQ_TELEM, '1);             // one-shot telemetry
		send_request(REQ_TICK, '0);              // throttle with telemetry bit
		send_request(REQ_TICK, '0);              // repeat last, flag now clear
		send_request(REQ_WRITE, RAW_W'(48));     // exactly the throttle floor
		send_request(REQ_WRITE, RAW_W'(47));     // fill the command queue
		send_request(REQ_WRITE, RAW_W'(1));
		send_request(REQ_WRITE, RAW_W'(42));
		send_request(REQ_WRITE, RAW_W'(21));
		send_request(REQ_WRITE, RAW_W'(5));
		send_request(REQ_WRITE, RAW_W'(10));
		send_request(REQ_WRITE, RAW_W'(20));
		send_request(REQ_WRITE, RAW_W'(30));
		send_request(REQ_WRITE, RAW_W'(33));     // queue full
		send_request(REQ_TICK, '0);              // oldest command beats throttle
		send_request(REQ_TICK, '0);
		send_request(REQ_WRITE, RAW_W'(2047));
		in_valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			settle();
			program_phase(p);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 83;
				end
				default: begin
					send_idle_pct  = 35;
					recv_stall_pct = 35;
				end
			endcase
			if (p == 4)
				hold_off_req = 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				n = $urandom_range(99);
				if (n < 50)
					send_request(REQ_WRITE, pick_raw());
				else if (n < 60)
					send_request(REQ_TELEM, RAW_W'($urandom));
				else if (n < 92)
					send_request(REQ_TICK, RAW_W'($urandom));
				else
					send_request(REQ_SPARE, RAW_W'($urandom));
			end
			in_valid <= 1'b0;
		end

		// drain with the receiver open so stray results show up
		recv_stall_pct = 0;
		settle();
		if (board.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
